// File: sv/matrix_multiply_engine_macros.svh
// assertion macros shared by the matrix product engine checkers
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mme_pkg.sv
// types, constants and helpers shared by the matrix product engine
package mme_pkg;

    localparam int MAX_DIM     = 16;
    localparam int VALUE_WIDTH = 16;

    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 5;
    localparam int CNT_W      = (IDX_W + 1 > DIM_W) ? IDX_W + 1 : DIM_W;
    localparam int DEPTH      = MAX_DIM * MAX_DIM;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int MUL_W      = 2 * VALUE_WIDTH;
    localparam int PROD_W     = 40;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 4;
    localparam int IN_VALUE_W = 16;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // item modes
    localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RD_C = 2'd2;

    // register indexes
    localparam logic [1:0] REG_DIM_M       = 2'd0;
    localparam logic [1:0] REG_DIM_K       = 2'd1;
    localparam logic [1:0] REG_DIM_L       = 2'd2;
    localparam logic [1:0] REG_TRANSPOSE_A = 2'd3;

    typedef logic [CNT_W-1:0]               cnt_t;
    typedef logic [ADDR_W-1:0]              addr_t;
    typedef logic signed [VALUE_WIDTH-1:0]  elem_t;
    typedef logic signed [MUL_W-1:0]        mul_t;
    typedef logic signed [PROD_W-1:0]       prod_t;

    typedef struct packed {
        cnt_t m;
        cnt_t k;
        cnt_t l;
        logic transpose;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic vld;
        logic last;
    } mac_ctl_t;

    // clamp a dimension register to the store size
    function automatic cnt_t eff_dim(logic [DIM_W-1:0] d);
        cnt_t de;
        de = cnt_t'(d);
        if (de > cnt_t'(MAX_DIM))
        begin
            return cnt_t'(MAX_DIM);
        end
        return de;
    endfunction

    // row-major element address
    function automatic addr_t elem_addr(cnt_t r, cnt_t c);
        return addr_t'(int'(r) * MAX_DIM + int'(c));
    endfunction

endpackage

// File: sv/mme_ram.sv
// generic single-write single-read synchronous ram, registered read data
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/mme_mac.sv
// multiply-accumulate unit fed by the two element stores
module mme_mac (
    input  logic             clk,
    input  logic             rst_n,
    input  mme_pkg::mac_ctl_t ctl,
    input  mme_pkg::elem_t   a_data,
    input  mme_pkg::elem_t   b_data,
    output mme_pkg::prod_t   acc,
    output logic             done
);
    import mme_pkg::*;

    logic  rd_vld_reg;
    logic  rd_last_reg;
    logic  mul_vld_reg;
    logic  mul_last_reg;
    logic  done_reg;
    mul_t  mul_reg;
    prod_t acc_reg;
    prod_t acc_next;

    // ram data arrives in the cycle after the read is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            mul_vld_reg  <= 1'b0;
            mul_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= ctl.vld;
            rd_last_reg  <= ctl.vld & ctl.last;
            mul_vld_reg  <= rd_vld_reg;
            mul_last_reg <= rd_last_reg;
            done_reg     <= mul_vld_reg & mul_last_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (mul_vld_reg)
        begin
            acc_next = acc_reg + prod_t'(mul_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_t'(a_data) * mul_t'(b_data);
        acc_reg <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

// File: sv/mme_seq.sv
// item sequencer: bounds checks, store writes, inner-dimension walk, result register
module mme_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mme_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mme_pkg::MODE_W-1:0]    mode,
    input  logic [mme_pkg::POS_W-1:0]     row,
    input  logic [mme_pkg::POS_W-1:0]     col,
    input  logic signed [mme_pkg::IN_VALUE_W-1:0] value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          status,
    output mme_pkg::prod_t                product,
    output logic                          a_we,
    output logic                          b_we,
    output mme_pkg::addr_t                waddr,
    output mme_pkg::elem_t                wdata,
    output mme_pkg::addr_t                a_raddr,
    output mme_pkg::addr_t                b_raddr,
    output mme_pkg::mac_ctl_t             mac_ctl,
    input  mme_pkg::prod_t                mac_acc,
    input  logic                          mac_done
);
    import mme_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    cnt_t       i_reg;
    cnt_t       i_next;
    cnt_t       row_reg;
    cnt_t       row_next;
    cnt_t       col_reg;
    cnt_t       col_next;
    logic       pend_status_reg;
    logic       pend_status_next;
    prod_t      pend_product_reg;
    prod_t      pend_product_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       status_reg;
    logic       status_next;
    prod_t      product_reg;
    prod_t      product_next;

    cnt_t       row_in;
    cnt_t       col_in;
    cnt_t       a_rmax;
    cnt_t       a_cmax;
    logic       a_ok;
    logic       b_ok;
    logic       c_ok;
    logic       last_step;

    assign row_in = cnt_t'(row);
    assign col_in = cnt_t'(col);
    assign a_rmax = cfg.transpose ? cfg.k : cfg.m;
    assign a_cmax = cfg.transpose ? cfg.m : cfg.k;
    assign a_ok   = (row_in < a_rmax) && (col_in < a_cmax);
    assign b_ok   = (row_in < cfg.k) && (col_in < cfg.l);
    assign c_ok   = (row_in < cfg.m) && (col_in < cfg.l);

    assign last_step = (i_reg == cfg.k - cnt_t'(1));

    assign in_stall = (state_reg != S_IDLE);
    assign waddr    = elem_addr(row_in, col_in);
    assign wdata    = elem_t'(value);
    assign a_raddr  = cfg.transpose ? elem_addr(i_reg, row_reg) : elem_addr(row_reg, i_reg);
    assign b_raddr  = elem_addr(i_reg, col_reg);

    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        pend_status_next  = pend_status_reg;
        pend_product_next = pend_product_reg;
        out_valid_next    = out_valid_reg & out_stall;
        status_next       = status_reg;
        product_next      = product_reg;
        a_we              = 1'b0;
        b_we              = 1'b0;
        mac_ctl           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    row_next          = row_in;
                    col_next          = col_in;
                    i_next            = '0;
                    pend_product_next = '0;
                    pend_status_next  = 1'b1;
                    state_next        = S_DONE;
                    case (mode)
                        MODE_WR_A:
                        begin
                            a_we             = a_ok;
                            pend_status_next = !a_ok;
                        end
                        MODE_WR_B:
                        begin
                            b_we             = b_ok;
                            pend_status_next = !b_ok;
                        end
                        MODE_RD_C:
                        begin
                            pend_status_next = !c_ok;
                            // empty inner dimension sums to zero
                            if (c_ok && (cfg.k != '0))
                            begin
                                mac_ctl.clear = 1'b1;
                                state_next    = S_RUN;
                            end
                        end
                        default:
                        begin
                            pend_status_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                mac_ctl.vld  = 1'b1;
                mac_ctl.last = last_step;
                i_next       = i_reg + cnt_t'(1);
                if (last_step)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (mac_done)
                begin
                    pend_product_next = mac_acc;
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = pend_status_reg;
                    product_next   = pend_product_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg            <= i_next;
        row_reg          <= row_next;
        col_reg          <= col_next;
        pend_status_reg  <= pend_status_next;
        pend_product_reg <= pend_product_next;
        status_reg       <= status_next;
        product_reg      <= product_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign product   = product_reg;

endmodule

// File: sv/matrix_multiply_engine.sv
// matrix product engine top level: configuration registers, element stores, sequencer, mac
//
// Computes single elements of C = op(A) x B in signed Q8.8, giving exact Q16.16 in 40 bits.
// An item with mode 0 or 1 writes one element of A or B at (row, col); mode 2 asks for
// C[row][col], which is walked over the inner dimension with one multiply-accumulate per
// cycle; mode 3 and any index outside the configured dimensions return status 1 and a
// zero product, with nothing stored. Every item gives exactly one result item. Both
// stores are synchronous rams with registered read data and are undefined until
// written, so read only elements you have written. Items are taken one at a time: a
// write goes through the result hand-off before the next item is accepted, a product
// read first issues one ram read per inner step (clamped dim_k), then passes the ram,
// multiplier and accumulator stages and the result hand-off; a read with dim_k of
// zero goes straight to the hand-off and answers 0. A finished result waits in the
// output register while the next item is accepted. Configuration goes through the apb
// port (dim_m at 0x0, dim_k at 0x4, dim_l at 0x8, transpose_a at 0xc) and must only be
// written while idle; dimension values above the store size act as the store size.
module matrix_multiply_engine (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [mme_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [mme_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [mme_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [mme_pkg::MODE_W-1:0]             mode,
    input  logic [mme_pkg::POS_W-1:0]              row,
    input  logic [mme_pkg::POS_W-1:0]              col,
    input  logic signed [mme_pkg::IN_VALUE_W-1:0]  value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   status,
    output logic signed [mme_pkg::PROD_W-1:0]      product
);
    import mme_pkg::*;

    // configuration registers
    logic [DIM_W-1:0] dim_m_reg;
    logic [DIM_W-1:0] dim_k_reg;
    logic [DIM_W-1:0] dim_l_reg;
    logic             transpose_a_reg;
    logic [1:0]       reg_idx;
    logic             cfg_wr;
    cfg_t             cfg;

    // store and mac wiring
    logic             a_we;
    logic             b_we;
    addr_t            waddr;
    elem_t            wdata;
    addr_t            a_raddr;
    addr_t            b_raddr;
    elem_t            a_rdata;
    elem_t            b_rdata;
    mac_ctl_t         mac_ctl;
    prod_t            mac_acc;
    logic             mac_done;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_m_reg       <= DIM_W'(16);
            dim_k_reg       <= DIM_W'(16);
            dim_l_reg       <= DIM_W'(16);
            transpose_a_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DIM_M:       dim_m_reg       <= pwdata[DIM_W-1:0];
                REG_DIM_K:       dim_k_reg       <= pwdata[DIM_W-1:0];
                REG_DIM_L:       dim_l_reg       <= pwdata[DIM_W-1:0];
                REG_TRANSPOSE_A: transpose_a_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        case (reg_idx)
            REG_DIM_M:       prdata = APB_DATA_W'(dim_m_reg);
            REG_DIM_K:       prdata = APB_DATA_W'(dim_k_reg);
            REG_DIM_L:       prdata = APB_DATA_W'(dim_l_reg);
            REG_TRANSPOSE_A: prdata = APB_DATA_W'(transpose_a_reg);
            default:         prdata = '0;
        endcase
    end

    // dimensions clamped to the store size
    assign cfg.m         = eff_dim(dim_m_reg);
    assign cfg.k         = eff_dim(dim_k_reg);
    assign cfg.l         = eff_dim(dim_l_reg);
    assign cfg.transpose = transpose_a_reg;

    // element stores, row-major, one write and one read port each
    mme_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mme_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    // one item at a time, so a read never overlaps a write to the same element
    mme_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .product   (product),
        .a_we      (a_we),
        .b_we      (b_we),
        .waddr     (waddr),
        .wdata     (wdata),
        .a_raddr   (a_raddr),
        .b_raddr   (b_raddr),
        .mac_ctl   (mac_ctl),
        .mac_acc   (mac_acc),
        .mac_done  (mac_done)
    );

    // multiply registered, then accumulated modulo 2^40
    mme_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .a_data (a_rdata),
        .b_data (b_rdata),
        .acc    (mac_acc),
        .done   (mac_done)
    );

endmodule

// File: sv/mme_checker.sv
// port-level checker for the matrix product engine, bound to the top level
`include "matrix_multiply_engine_macros.svh"

module mme_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic                              status,
    input logic signed [mme_pkg::PROD_W-1:0] product
);
    import mme_pkg::*;

    // a stalled result stays offered
    `MME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `MME_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(status) && $stable(product), "result changed while stalled")

    // error results never carry a product
    `MME_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && status, product == '0, "error result with nonzero product")

    // the engine works on one item at a time
    `MME_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

// File: sim/testbench.sv
// self-checking testbench for the matrix product engine
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    // mode code with no operation behind it, answered with an error
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake of any kind
    localparam int RANDOM_PHASES  = 12;
    localparam int RANDOM_ITEMS   = 100;    // items per random phase

    // one result item as the engine should deliver it
    typedef struct packed {
        logic  status;
        prod_t product;
    } outcome_t;

    // engine ports, the inputs at known values from time zero
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   psel      = 1'b0;
    logic                   penable   = 1'b0;
    logic                   pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr     = '0;
    logic [APB_DATA_W-1:0]  pwdata    = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [MODE_W-1:0]      mode      = '0;
    logic [POS_W-1:0]       row       = '0;
    logic [POS_W-1:0]       col       = '0;
    logic signed [IN_VALUE_W-1:0] value = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   status;
    prod_t                  product;

    // shadow of the configuration registers, reset values
    logic [DIM_W-1:0] cfg_m         = 5'd16;
    logic [DIM_W-1:0] cfg_k         = 5'd16;
    logic [DIM_W-1:0] cfg_l         = 5'd16;
    logic             cfg_transpose = 1'b0;

    // shadow of both element stores, addressed row * MAX_DIM + col
    elem_t a_elems [DEPTH];
    elem_t b_elems [DEPTH];

    // results owed by the engine, oldest first
    outcome_t awaited_products [$];

    int fail_count = 0;

    // pacing knobs for the sender and the receiver
    int gap_max    = 0;     // longest idle gap between bursts
    int burst_left = 0;     // items still to go in the current burst
    int stall_pct  = 0;     // chance of a receiver stall per cycle
    int stall_hold = 0;     // remaining cycles of a long stall

    matrix_multiply_engine uut (.*);

    always #5 clk = ~clk;

    // clamp a dimension register to the store size
    function automatic int clamp_dim(input logic [DIM_W-1:0] d);
        return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // expected result of one item, updating the shadow stores for writes
    function automatic outcome_t product_element(input logic [MODE_W-1:0] op,
                                                 input logic [POS_W-1:0] r,
                                                 input logic [POS_W-1:0] c,
                                                 input elem_t v);
        outcome_t res;
        int       m_eff;
        int       k_eff;
        int       l_eff;
        int       a_rows;
        int       a_cols;
        int       a_idx;
        int       i;
        longint   acc;
        res.status  = 1'b1;
        res.product = '0;
        m_eff  = clamp_dim(cfg_m);
        k_eff  = clamp_dim(cfg_k);
        l_eff  = clamp_dim(cfg_l);
        // a transposed A is held k by m
        a_rows = cfg_transpose ? k_eff : m_eff;
        a_cols = cfg_transpose ? m_eff : k_eff;
        case (op)
            MODE_WR_A:
            begin
                if (int'(r) < a_rows && int'(c) < a_cols)
                begin
                    a_elems[int'(r) * MAX_DIM + int'(c)] = v;
                    res.status = 1'b0;
                end
            end
            MODE_WR_B:
            begin
                if (int'(r) < k_eff && int'(c) < l_eff)
                begin
                    b_elems[int'(r) * MAX_DIM + int'(c)] = v;
                    res.status = 1'b0;
                end
            end
            MODE_RD_C:
            begin
                if (int'(r) < m_eff && int'(c) < l_eff)
                begin
                    acc = 0;
                    for (i = 0; i < k_eff; i++)
                    begin
                        a_idx = cfg_transpose ? i * MAX_DIM + int'(r) : int'(r) * MAX_DIM + i;
                        acc += longint'(a_elems[a_idx]) * longint'(b_elems[i * MAX_DIM + int'(c)]);
                    end
                    res.product = prod_t'(acc);
                    res.status  = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // index below the limit most of the time, anywhere otherwise
    function automatic logic [POS_W-1:0] pick_index(input int lim);
        if (lim == 0 || $urandom_range(0, 99) < 15)
            return POS_W'($urandom_range(0, 15));
        return POS_W'($urandom_range(0, lim - 1));
    endfunction

    // element value with the extremes favoured
    function automatic elem_t pick_value();
        case ($urandom_range(0, 19))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return elem_t'($urandom);
        endcase
    endfunction

    // dimension register value, zero and over-size ones included
    function automatic int random_dim();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(17, 31);
            2, 3: return 16;
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // receiver: random stalls at the phase's rate, now and then a long one
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold <= stall_hold - 1;
            out_stall  <= 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(0, 99) < 2)
        begin
            stall_hold <= $urandom_range(4, 19);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result checker: each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (awaited_products.size() == 0)
            begin
                $error("unexpected result item: status %0d, product %0d", status, product);
                fail_count++;
            end
            else
            begin
                want = awaited_products.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
                if (product !== want.product)
                begin
                    $error("product: expected %0d, got %0d", want.product, product);
                    fail_count++;
                end
            end
        end
    end

    // hands one item over, records its expected result, then paces the sender
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] r,
                             input logic [POS_W-1:0] c, input elem_t v);
        int gap;
        in_valid <= 1'b1;
        mode     <= op;
        row      <= r;
        col      <= c;
        value    <= v;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        // item taken at this edge
        awaited_products.insert(awaited_products.size(), product_element(op, r, c, v));
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 11);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // stop sending and let every owed result come out
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (awaited_products.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of one register followed by a read back of it
    task automatic write_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] data);
        logic [APB_DATA_W-1:0] wanted;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        // register taken at this edge, only its low bits are kept
        case (idx)
            REG_DIM_M:       cfg_m = data[DIM_W-1:0];
            REG_DIM_K:       cfg_k = data[DIM_W-1:0];
            REG_DIM_L:       cfg_l = data[DIM_W-1:0];
            REG_TRANSPOSE_A: cfg_transpose = data[0];
            default:
            begin
            end
        endcase
        case (idx)
            REG_DIM_M:       wanted = APB_DATA_W'(cfg_m);
            REG_DIM_K:       wanted = APB_DATA_W'(cfg_k);
            REG_DIM_L:       wanted = APB_DATA_W'(cfg_l);
            default:         wanted = APB_DATA_W'(cfg_transpose);
        endcase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        if (prdata !== wanted)
        begin
            $error("prdata: expected %0h, got %0h", wanted, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // new shape once the engine is idle, junk in the unused data bits
    task automatic configure(input int m, input int k, input int l, input bit tr);
        wait_results_done();
        write_register(REG_DIM_M, ($urandom & 32'hffff_ffe0) | APB_DATA_W'(m));
        write_register(REG_DIM_K, ($urandom & 32'hffff_ffe0) | APB_DATA_W'(k));
        write_register(REG_DIM_L, ($urandom & 32'hffff_ffe0) | APB_DATA_W'(l));
        write_register(REG_TRANSPOSE_A, ($urandom & 32'hffff_fffe) | APB_DATA_W'(tr));
        @(posedge clk);
    endtask

    // fill every element of both stores at the reset shape, so no read ever
    // touches an unwritten element; rows 14/15 of A and columns 14/15 of B hold
    // the extremes for the largest sums
    task automatic load_stores();
        int    r;
        int    c;
        elem_t v;
        gap_max    = 2;
        stall_pct  = 30;
        burst_left = 0;
        for (r = 0; r < MAX_DIM; r++)
        begin
            for (c = 0; c < MAX_DIM; c++)
            begin
                v = (r == 15) ? 16'sh8000 : (r == 14) ? 16'sh7fff : elem_t'($urandom);
                send_item(MODE_WR_A, POS_W'(r), POS_W'(c), v);
            end
        end
        for (r = 0; r < MAX_DIM; r++)
        begin
            for (c = 0; c < MAX_DIM; c++)
            begin
                v = (c == 15) ? 16'sh8000 : (c == 14) ? 16'sh7fff : elem_t'($urandom);
                send_item(MODE_WR_B, POS_W'(r), POS_W'(c), v);
            end
        end
    endtask

    // full-length sums at the value extremes and the unused mode
    task automatic test_extremes();
        gap_max    = 0;
        stall_pct  = 40;
        burst_left = 0;
        send_item(MODE_RD_C, 4'd15, 4'd15, 16'sh0000);   // largest positive sum
        send_item(MODE_RD_C, 4'd14, 4'd15, 16'sh7fff);   // largest negative sum
        send_item(MODE_RD_C, 4'd15, 4'd14, 16'sh8000);
        send_item(MODE_RD_C, 4'd14, 4'd14, 16'shffff);
        send_item(MODE_UNUSED, 4'd15, 4'd15, 16'sh8000);
        send_item(MODE_UNUSED, 4'd0, 4'd0, 16'sh7fff);
    endtask

    // bounds on every dimension, zero and over-size dimensions, transposed A
    task automatic test_bounds();
        gap_max = 3;
        // single element, the matrix-vector corner
        configure(1, 1, 1, 1'b0);
        send_item(MODE_WR_A, 4'd0, 4'd0, 16'sh7fff);
        send_item(MODE_WR_B, 4'd0, 4'd0, 16'sh8000);
        send_item(MODE_RD_C, 4'd0, 4'd0, 16'sh0000);
        send_item(MODE_WR_A, 4'd1, 4'd0, 16'sh1234);
        send_item(MODE_WR_B, 4'd0, 4'd1, 16'sh1234);
        send_item(MODE_RD_C, 4'd0, 4'd1, 16'sh0000);
        send_item(MODE_RD_C, 4'd1, 4'd0, 16'sh0000);
        // transposed A is held k by m
        configure(2, 3, 1, 1'b1);
        send_item(MODE_WR_A, 4'd2, 4'd1, 16'shffff);
        send_item(MODE_WR_A, 4'd1, 4'd2, 16'sh0005);
        send_item(MODE_WR_B, 4'd2, 4'd0, 16'sh0100);
        send_item(MODE_RD_C, 4'd1, 4'd0, 16'sh0000);
        send_item(MODE_RD_C, 4'd2, 4'd0, 16'sh0000);
        // empty inner dimension: reads give zero, writes have nowhere to go
        configure(3, 0, 3, 1'b0);
        send_item(MODE_RD_C, 4'd2, 4'd2, 16'sh0000);
        send_item(MODE_WR_A, 4'd0, 4'd0, 16'sh0001);
        send_item(MODE_WR_B, 4'd0, 4'd0, 16'sh0001);
        // no rows at all
        configure(0, 16, 16, 1'b0);
        send_item(MODE_RD_C, 4'd0, 4'd0, 16'sh0000);
        send_item(MODE_WR_A, 4'd0, 4'd0, 16'sh0001);
        // register values past the store size act as the store size
        configure(31, 31, 31, 1'b1);
        send_item(MODE_RD_C, 4'd15, 4'd15, 16'sh0000);
        send_item(MODE_WR_A, 4'd15, 4'd15, elem_t'($urandom));
    endtask

    // one random item shaped by the current dimensions
    task automatic random_item(output logic [MODE_W-1:0] op, output logic [POS_W-1:0] r,
                               output logic [POS_W-1:0] c, output elem_t v);
        int pick;
        int m_eff;
        int k_eff;
        int l_eff;
        pick  = $urandom_range(0, 99);
        m_eff = clamp_dim(cfg_m);
        k_eff = clamp_dim(cfg_k);
        l_eff = clamp_dim(cfg_l);
        if (pick < 30)
            op = MODE_WR_A;
        else if (pick < 60)
            op = MODE_WR_B;
        else if (pick < 95)
            op = MODE_RD_C;
        else
            op = MODE_UNUSED;
        case (op)
            MODE_WR_A:
            begin
                r = pick_index(cfg_transpose ? k_eff : m_eff);
                c = pick_index(cfg_transpose ? m_eff : k_eff);
            end
            MODE_WR_B:
            begin
                r = pick_index(k_eff);
                c = pick_index(l_eff);
            end
            MODE_RD_C:
            begin
                r = pick_index(m_eff);
                c = pick_index(l_eff);
            end
            default:
            begin
                r = POS_W'($urandom);
                c = POS_W'($urandom);
            end
        endcase
        v = pick_value();
    endtask

    // random traffic over a run of shapes, each phase with its own pacing
    task automatic test_random_shapes();
        int p;
        int n;
        logic [MODE_W-1:0] op;
        logic [POS_W-1:0]  r;
        logic [POS_W-1:0]  c;
        elem_t             v;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: configure(16, 16, 16, 1'b0);
                1: configure(1, 1, 1, 1'b0);
                2: configure(31, 31, 31, 1'b1);
                3: configure(16, 16, 1, 1'b0);       // matrix times vector
                4: configure(4, 16, 4, 1'b1);
                default: configure(random_dim(), random_dim(), random_dim(), 1'($urandom));
            endcase
            // first phase runs flat out on both sides
            if (p == 0)
            begin
                gap_max   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_max   = $urandom_range(0, 3) * 4;
                stall_pct = $urandom_range(0, 4) * 20;
            end
            burst_left = 0;
            for (n = 0; n < RANDOM_ITEMS; n++)
            begin
                // halfway through, hold off until the engine has caught up
                if (n == RANDOM_ITEMS / 2)
                    wait_results_done();
                random_item(op, r, c, v);
                send_item(op, r, c, v);
            end
        end
    endtask

    // watchdog: too long without any handshake ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
                || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_stores();
        test_extremes();
        test_bounds();
        test_random_shapes();
        wait_results_done();
        if (fail_count == 0 && awaited_products.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
